FILE: hw/rtl/sig_pkg.sv
// shared types and codes of the stepper interval generator
`timescale 1ns / 1ps

package sig_pkg;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_CHK,
		ST_DIV,
		ST_DIV_END,
		ST_EM_CHK,
		ST_EM_STEP,
		ST_PC_SPLIT,
		ST_PC_AFTER,
		ST_PC_TIME,
		ST_OUT
	} st_t;

	// atom kinds on the result stream
	localparam logic [2:0] ATOM_NONE     = 3'd0;
	localparam logic [2:0] ATOM_INTERVAL = 3'd1;
	localparam logic [2:0] ATOM_ENABLE   = 3'd2;
	localparam logic [2:0] ATOM_DISABLE  = 3'd3;
	localparam logic [2:0] ATOM_DIR_POS  = 3'd4;
	localparam logic [2:0] ATOM_DIR_NEG  = 3'd5;

	// step enable state codes
	localparam logic [1:0] EN_INVALID  = 2'd0;
	localparam logic [1:0] EN_ENABLED  = 2'd1;
	localparam logic [1:0] EN_DISABLED = 2'd2;

	// current direction codes
	localparam logic [1:0] DIRC_INVALID = 2'd0;
	localparam logic [1:0] DIRC_POS     = 2'd1;
	localparam logic [1:0] DIRC_NEG     = 2'd2;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	// config register indexes
	localparam logic REG_MIN_PIECE = 1'b0;

	// shortest piece reset value and upper clamp limit
	localparam logic [14:0] MIN_PIECE_RST = 15'd1024;
	localparam logic [14:0] MIN_PIECE_MAX = 15'd16384;

	// number of quotient bits, one per divide step
	localparam int DIV_STEPS = 32;

endpackage

FILE: hw/rtl/stepper_interval_generator.sv
// stepper interval generator: move loader, divider and atom sequencer
`timescale 1ns / 1ps

// One axis of step timing. A load request (cmd 0) takes a move time and a
// signed step count and divides the time by the distance with a restoring
// divider, one quotient bit a cycle, after a borrow check that rejects a
// move with more steps than time; a zero-distance load skips the divider.
// An emit request (cmd 1) returns one timer atom (interval piece,
// enable/disable step, direction or none), the sequencer stepping the single
// shared 33-bit adder through the compare, split and time-update steps. A
// result waits while an earlier one still sits unaccepted in the output
// register. One request is worked on at a time; s_tready is high only while
// the sequencer is idle, so the next request can be taken in the same cycle
// that a result is presented. A finished result waits in the output register
// while the next request is worked on. min_piece is at byte address 0 and
// is clamped to 1..16384 when used.
module stepper_interval_generator (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // move_time[31:0], move_distance[55:32]
	input  logic [0:0]  s_tuser,   // cmd[0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // interval_ticks[15:0], move_done[16], bad_move[17]
	output logic [2:0]  m_tuser,   // atom_kind[2:0]
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	sig_pkg::st_t state_q, state_d;

	// configuration
	logic [14:0] min_piece_q;

	// request latch
	logic [31:0] mt_q;
	logic [23:0] dist_q;
	logic        neg_q;

	// move state
	logic [31:0] total_time_q;
	logic [31:0] time_emitted_q;
	logic [31:0] step_quotient_q;
	logic [23:0] err_increment_q;
	logic [23:0] err_decrement_q;
	logic [24:0] err_accum_q;
	logic [31:0] piece_remaining_q;
	logic        stepping_active_q;
	logic [1:0]  enable_state_q;
	logic [1:0]  dir_current_q;
	logic        dir_wanted_q;

	// divider
	logic [31:0] quo_q;
	logic [23:0] rem_q;
	logic [4:0]  div_cnt_q;
	logic [24:0] rem_sh;

	// current piece and result
	logic [15:0] piece_q;
	logic [2:0]  kind_q;
	logic [15:0] ticks_q;
	logic        bad_q;

	// output register
	logic        m_tvalid_q;
	logic [2:0]  m_tuser_q;
	logic [23:0] m_tdata_q;

	// shared adder
	logic [31:0] alu_a;
	logic [31:0] alu_b;
	logic        alu_sub;
	logic [32:0] alu_res;
	logic        alu_borrow;

	// derived values
	logic [14:0] lo_eff;
	logic [15:0] hi_eff;
	logic [23:0] raw_dist;
	logic        raw_neg;
	logic [23:0] abs_dist;
	logic        accum_pos;
	logic [1:0]  dir_want_code;
	logic [1:0]  en_want;
	logic        out_free;
	logic        s_acc;
	logic        cfg_wr;

	assign s_acc    = s_tvalid && s_tready;
	assign s_tready = (state_q == sig_pkg::ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// request decode: magnitude of the signed distance
	assign raw_dist = s_tdata[55:32];
	assign raw_neg  = raw_dist[23];
	assign abs_dist = raw_neg ? (~raw_dist + 24'd1) : raw_dist;

	// clamped piece limits
	always_comb begin
		if (min_piece_q == 15'd0) begin
			lo_eff = 15'd1;
		end else if (min_piece_q > sig_pkg::MIN_PIECE_MAX) begin
			lo_eff = sig_pkg::MIN_PIECE_MAX;
		end else begin
			lo_eff = min_piece_q;
		end
	end
	assign hi_eff = 16'(17'h10000 - {2'b00, lo_eff});

	assign rem_sh        = {rem_q, quo_q[31]};
	assign accum_pos     = !err_accum_q[24] && (err_accum_q != 25'd0);
	assign dir_want_code = dir_wanted_q ? sig_pkg::DIRC_NEG : sig_pkg::DIRC_POS;

	// shared adder operand select
	always_comb begin
		alu_a   = 32'd0;
		alu_b   = 32'd0;
		alu_sub = 1'b0;
		case (state_q)
			sig_pkg::ST_DIV_CHK: begin
				alu_a   = mt_q;
				alu_b   = {8'd0, dist_q};
				alu_sub = 1'b1;
			end
			sig_pkg::ST_DIV: begin
				alu_a   = {7'd0, rem_sh};
				alu_b   = {8'd0, dist_q};
				alu_sub = 1'b1;
			end
			sig_pkg::ST_DIV_END: begin
				alu_a   = {8'd0, dist_q};
				alu_b   = {8'd0, rem_q};
				alu_sub = 1'b1;
			end
			sig_pkg::ST_EM_CHK: begin
				alu_a   = total_time_q;
				alu_b   = time_emitted_q;
				alu_sub = 1'b1;
			end
			sig_pkg::ST_EM_STEP: begin
				alu_a   = step_quotient_q;
				alu_b   = {31'd0, accum_pos};
			end
			sig_pkg::ST_PC_SPLIT: begin
				alu_a   = piece_remaining_q;
				alu_b   = {16'd0, hi_eff};
				alu_sub = 1'b1;
			end
			sig_pkg::ST_PC_AFTER: begin
				alu_a   = piece_remaining_q;
				alu_b   = {16'd0, piece_q};
				alu_sub = 1'b1;
			end
			sig_pkg::ST_PC_TIME: begin
				alu_a   = time_emitted_q;
				alu_b   = {16'd0, piece_q};
			end
			default: begin
				alu_a   = 32'd0;
			end
		endcase
	end
	assign alu_res    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {32'd0, alu_sub};
	assign alu_borrow = alu_sub && !alu_res[32];

	// enable state wanted for the piece under way
	assign en_want = ((alu_res[31:0] == 32'd0) && stepping_active_q) ?
		sig_pkg::EN_ENABLED : sig_pkg::EN_DISABLED;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sig_pkg::ST_IDLE: begin
				if (s_acc) begin
					if (s_tuser[0] == sig_pkg::CMD_EMIT) begin
						state_d = sig_pkg::ST_EM_CHK;
					end else if (abs_dist == 24'd0) begin
						state_d = sig_pkg::ST_OUT;
					end else begin
						state_d = sig_pkg::ST_DIV_CHK;
					end
				end
			end
			sig_pkg::ST_DIV_CHK: begin
				state_d = alu_borrow ? sig_pkg::ST_OUT : sig_pkg::ST_DIV;
			end
			sig_pkg::ST_DIV: begin
				if (div_cnt_q == 5'(sig_pkg::DIV_STEPS - 1)) begin
					state_d = sig_pkg::ST_DIV_END;
				end
			end
			sig_pkg::ST_DIV_END: begin
				state_d = sig_pkg::ST_OUT;
			end
			sig_pkg::ST_EM_CHK: begin
				if (piece_remaining_q != 32'd0) begin
					state_d = sig_pkg::ST_PC_SPLIT;
				end else if (alu_res[31:0] == 32'd0) begin
					state_d = sig_pkg::ST_OUT;
				end else if (!stepping_active_q) begin
					state_d = sig_pkg::ST_PC_SPLIT;
				end else begin
					state_d = sig_pkg::ST_EM_STEP;
				end
			end
			sig_pkg::ST_EM_STEP: begin
				if (dir_current_q != dir_want_code) begin
					state_d = sig_pkg::ST_OUT;
				end else if (alu_res[31:0] == 32'd0) begin
					state_d = sig_pkg::ST_OUT;
				end else begin
					state_d = sig_pkg::ST_PC_SPLIT;
				end
			end
			sig_pkg::ST_PC_SPLIT: begin
				state_d = sig_pkg::ST_PC_AFTER;
			end
			sig_pkg::ST_PC_AFTER: begin
				state_d = (enable_state_q != en_want) ? sig_pkg::ST_OUT : sig_pkg::ST_PC_TIME;
			end
			sig_pkg::ST_PC_TIME: begin
				state_d = sig_pkg::ST_OUT;
			end
			sig_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = sig_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sig_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sig_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration register
	assign cfg_wr = psel && penable && pwrite && pready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_piece_q <= sig_pkg::MIN_PIECE_RST;
		end else if (cfg_wr && (paddr[2] == sig_pkg::REG_MIN_PIECE)) begin
			min_piece_q <= pwdata[14:0];
		end
	end
	assign pready = 1'b1;
	assign prdata = (paddr[2] == sig_pkg::REG_MIN_PIECE) ? {17'd0, min_piece_q} : 32'd0;

	// request latch and divider payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			mt_q   <= s_tdata[31:0];
			dist_q <= abs_dist;
			neg_q  <= raw_neg;
		end
		if (state_q == sig_pkg::ST_DIV_CHK) begin
			quo_q <= mt_q;
			rem_q <= 24'd0;
		end else if (state_q == sig_pkg::ST_DIV) begin
			quo_q <= {quo_q[30:0], !alu_borrow};
			rem_q <= alu_borrow ? rem_sh[23:0] : alu_res[23:0];
		end
	end

	// move state and sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_time_q      <= 32'd0;
			time_emitted_q    <= 32'd0;
			step_quotient_q   <= 32'd0;
			err_increment_q   <= 24'd0;
			err_decrement_q   <= 24'd0;
			err_accum_q       <= 25'd0;
			piece_remaining_q <= 32'd0;
			stepping_active_q <= 1'b0;
			enable_state_q    <= sig_pkg::EN_INVALID;
			dir_current_q     <= sig_pkg::DIRC_INVALID;
			dir_wanted_q      <= 1'b0;
			div_cnt_q         <= 5'd0;
			piece_q           <= 16'd0;
			kind_q            <= sig_pkg::ATOM_NONE;
			ticks_q           <= 16'd0;
			bad_q             <= 1'b0;
		end else begin
			case (state_q)
				sig_pkg::ST_IDLE: begin
					kind_q  <= sig_pkg::ATOM_NONE;
					ticks_q <= 16'd0;
					bad_q   <= 1'b0;
					// zero distance marks time with stepping off
					if (s_acc && (s_tuser[0] == sig_pkg::CMD_LOAD) && (abs_dist == 24'd0)) begin
						stepping_active_q <= 1'b0;
						total_time_q      <= s_tdata[31:0];
						time_emitted_q    <= 32'd0;
						piece_remaining_q <= 32'd0;
					end
				end
				sig_pkg::ST_DIV_CHK: begin
					div_cnt_q <= 5'd0;
					bad_q     <= alu_borrow;
				end
				sig_pkg::ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
				end
				sig_pkg::ST_DIV_END: begin
					step_quotient_q   <= quo_q;
					err_increment_q   <= rem_q;
					err_decrement_q   <= alu_res[23:0];
					err_accum_q       <= 25'd0;
					stepping_active_q <= 1'b1;
					piece_remaining_q <= 32'd0;
					enable_state_q    <= sig_pkg::EN_INVALID;
					total_time_q      <= mt_q;
					time_emitted_q    <= 32'd0;
					dir_wanted_q      <= neg_q;
				end
				sig_pkg::ST_EM_CHK: begin
					// idle move: the rest of the time becomes the piece
					if ((piece_remaining_q == 32'd0) && !stepping_active_q) begin
						piece_remaining_q <= alu_res[31:0];
					end
				end
				sig_pkg::ST_EM_STEP: begin
					if (dir_current_q != dir_want_code) begin
						dir_current_q <= dir_want_code;
						kind_q <= dir_wanted_q ? sig_pkg::ATOM_DIR_NEG : sig_pkg::ATOM_DIR_POS;
					end else begin
						// bresenham: long interval when the error is positive
						if (accum_pos) begin
							err_accum_q <= err_accum_q - {1'b0, err_decrement_q};
						end else begin
							err_accum_q <= err_accum_q + {1'b0, err_increment_q};
						end
						piece_remaining_q <= alu_res[31:0];
					end
				end
				sig_pkg::ST_PC_SPLIT: begin
					// fit the piece, never leaving a short tail
					if (alu_borrow) begin
						piece_q <= piece_remaining_q[15:0];
					end else if ((alu_res[31:15] == 17'd0) && (alu_res[14:0] < lo_eff)) begin
						piece_q <= {1'b0, hi_eff[15:1]};
					end else begin
						piece_q <= hi_eff;
					end
				end
				sig_pkg::ST_PC_AFTER: begin
					if (enable_state_q != en_want) begin
						enable_state_q <= en_want;
						kind_q <= (en_want == sig_pkg::EN_ENABLED) ?
							sig_pkg::ATOM_ENABLE : sig_pkg::ATOM_DISABLE;
					end else begin
						piece_remaining_q <= alu_res[31:0];
					end
				end
				sig_pkg::ST_PC_TIME: begin
					time_emitted_q <= alu_res[31:0];
					kind_q         <= sig_pkg::ATOM_INTERVAL;
					ticks_q        <= piece_q;
				end
				default: begin
					div_cnt_q <= div_cnt_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == sig_pkg::ST_OUT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if ((state_q == sig_pkg::ST_OUT) && out_free) begin
			m_tuser_q <= kind_q;
			m_tdata_q <= {6'd0, bad_q, (time_emitted_q == total_time_q), ticks_q};
		end
	end
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_ivl_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == sig_pkg::ATOM_INTERVAL)) |-> (m_tdata[15:0] != 16'd0))
		else $error("interval atom with zero ticks");

	a_ticks_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != sig_pkg::ATOM_INTERVAL)) |-> (m_tdata[15:0] == 16'd0))
		else $error("ticks set on a non-interval atom");

	a_div_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sig_pkg::ST_DIV) |=>
		((state_q == sig_pkg::ST_DIV) || (state_q == sig_pkg::ST_DIV_END)))
		else $error("divider left before its last step");

	a_bad_load: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[17]) |-> (m_tuser == sig_pkg::ATOM_NONE))
		else $error("bad move flagged on an emitted atom");

endmodule

FILE: sim/stepper_interval_generator_test.sv
// self-checking testbench of the stepper interval generator
`timescale 1ns / 1ps

module stepper_interval_generator_test;

	localparam int IDLE_LIMIT   = 5000;
	localparam int ITEM_TARGET  = 450;
	localparam int PHASE_ITEMS  = 75;
	localparam int LONG_HOLD    = 300;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] ticks;
		logic        done;
		logic        bad;
	} atom_t;

	// predicts the timer atoms of one axis and checks the ones the block returns
	class atom_tracker;
		logic [14:0] min_piece;
		logic [31:0] total_time, time_emitted, step_quotient, piece_left;
		logic [23:0] err_inc, err_dec;
		int          err_acc;
		bit          stepping;
		logic [1:0]  enable_state, dir_current;
		bit          dir_neg;
		atom_t       atoms_due[$];
		int          mismatches;
		int          atoms_seen;

		function new();
			min_piece = sig_pkg::MIN_PIECE_RST;
			total_time = '0;
			time_emitted = '0;
			step_quotient = '0;
			piece_left = '0;
			err_inc = '0;
			err_dec = '0;
			err_acc = 0;
			stepping = 0;
			enable_state = sig_pkg::EN_INVALID;
			dir_current = sig_pkg::DIRC_INVALID;
			dir_neg = 0;
			mismatches = 0;
			atoms_seen = 0;
		endfunction

		// piece length that avoids leaving a runt shorter than the minimum
		function logic [31:0] piece_len(logic [31:0] ivl);
			logic [31:0] lo, hi;
			lo = {17'd0, min_piece};
			if (lo < 1)
				lo = 1;
			if (lo > {17'd0, sig_pkg::MIN_PIECE_MAX})
				lo = {17'd0, sig_pkg::MIN_PIECE_MAX};
			hi = 32'h10000 - lo;
			if (ivl < hi)
				return ivl;
			if (ivl - hi < lo)
				return hi / 2;
			return hi;
		endfunction

		// one atom of the current piece run: an enable change first, else the piece
		function atom_t next_piece();
			atom_t       a;
			logic [31:0] p, left_after;
			logic [1:0]  want;
			a = '0;
			p = piece_len(piece_left);
			left_after = piece_left - p;
			want = (left_after == 0 && stepping) ? sig_pkg::EN_ENABLED : sig_pkg::EN_DISABLED;
			if (enable_state != want) begin
				enable_state = want;
				a.kind = (want == sig_pkg::EN_ENABLED) ?
					sig_pkg::ATOM_ENABLE : sig_pkg::ATOM_DISABLE;
				return a;
			end
			piece_left = left_after;
			time_emitted = time_emitted + p;
			a.kind = sig_pkg::ATOM_INTERVAL;
			a.ticks = p[15:0];
			return a;
		endfunction

		function void take_request(logic cmd, logic [31:0] t, logic [23:0] d);
			atom_t       a;
			logic [31:0] steps, ivl, r;
			bit          neg;
			a = '0;
			if (cmd == sig_pkg::CMD_LOAD) begin
				neg = d[23];
				steps = neg ? ((32'h1000000 - {8'd0, d}) & 32'hFFFFFF) : {8'd0, d};
				if (steps == 0) begin
					// time only, pulses stay off
					stepping = 0;
					total_time = t;
					time_emitted = '0;
					piece_left = '0;
				end else if (steps > t) begin
					a.bad = 1'b1;
				end else begin
					r = t % steps;
					step_quotient = t / steps;
					err_inc = r[23:0];
					err_dec = 24'(steps - r);
					err_acc = 0;
					stepping = 1;
					piece_left = '0;
					enable_state = sig_pkg::EN_INVALID;
					total_time = t;
					time_emitted = '0;
					dir_neg = neg;
				end
			end else if (piece_left != 0) begin
				a = next_piece();
			end else if (time_emitted != total_time) begin
				if (!stepping) begin
					piece_left = total_time - time_emitted;
					a = next_piece();
				end else if (dir_current != (dir_neg ? sig_pkg::DIRC_NEG : sig_pkg::DIRC_POS)) begin
					dir_current = dir_neg ? sig_pkg::DIRC_NEG : sig_pkg::DIRC_POS;
					a.kind = dir_neg ? sig_pkg::ATOM_DIR_NEG : sig_pkg::ATOM_DIR_POS;
				end else begin
					// bresenham: quotient or quotient plus one
					ivl = step_quotient;
					if (err_acc <= 0) begin
						err_acc = err_acc + int'(err_inc);
					end else begin
						ivl = ivl + 1;
						err_acc = err_acc - int'(err_dec);
					end
					piece_left = ivl;
					if (piece_left != 0)
						a = next_piece();
				end
			end
			a.done = (time_emitted == total_time);
			atoms_due.push_back(a);
		endfunction

		function void note_failure(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t, atom %0d: %s", $time, atoms_seen, msg);
		endfunction

		function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
			if (got_v !== want_v)
				note_failure($sformatf("%s expected %0d, got %0d", name, want_v, got_v));
		endfunction

		function void check_atom(logic [2:0] kind, logic [15:0] ticks, logic done, logic bad);
			atom_t want;
			if (atoms_due.size() == 0) begin
				note_failure($sformatf("unexpected atom, kind %0d ticks %0d", kind, ticks));
				return;
			end
			want = atoms_due.pop_front();
			compare_field("atom_kind", 32'(want.kind), 32'(kind));
			compare_field("interval_ticks", 32'(want.ticks), 32'(ticks));
			compare_field("move_done", 32'(want.done), 32'(done));
			compare_field("bad_move", 32'(want.bad), 32'(bad));
			atoms_seen++;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;   // move_time[31:0], move_distance[55:32]
	logic [0:0]  s_tuser = '0;   // cmd[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // interval_ticks[15:0], move_done[16], bad_move[17]
	logic [2:0]  m_tuser;        // atom_kind[2:0]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	atom_tracker tracker = new();

	int sent;
	int tx_steady;
	int hold_req = 0;
	int hold_seen = 0;
	int rx_stall = 0;
	int rx_run = 0;
	int rx_pick;
	int idle_cycles = 0;

	stepper_interval_generator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: check accepted atoms, random stalls, long hold on request
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			tracker.check_atom(m_tuser, m_tdata[15:0], m_tdata[16], m_tdata[17]);
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				rx_stall = LONG_HOLD;
				rx_run = 0;
			end
			if (rx_stall > 0) begin
				m_tready <= 1'b0;
				rx_stall--;
			end else if (rx_run > 0) begin
				m_tready <= 1'b1;
				rx_run--;
			end else begin
				rx_pick = $urandom_range(0, 99);
				if (rx_pick < 8) begin
					rx_run = $urandom_range(20, 80);
					m_tready <= 1'b1;
				end else if (rx_pick < 11) begin
					rx_stall = $urandom_range(15, 60);
					m_tready <= 1'b0;
				end else if (rx_pick < 30) begin
					rx_stall = $urandom_range(0, 2);
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// watchdog on cycles with no request or result accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// gap before the next request: mostly none or short, a few long
	function int pick_gap();
		int r;
		if (tx_steady > 0) begin
			tx_steady--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5)
			tx_steady = $urandom_range(20, 60);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_request(input logic cmd, input logic [31:0] t, input logic [23:0] d);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {d, t};
		s_tuser <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.take_request(cmd, t, d);
		sent++;
	endtask

	// emit requests carry random data, which the block ignores
	task automatic send_emits(input int n);
		for (int i = 0; i < n; i++)
			send_request(sig_pkg::CMD_EMIT, $urandom, 24'($urandom));
	endtask

	task automatic wait_drained();
		while (tracker.atoms_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_min_piece(input logic [14:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sig_pkg::REG_MIN_PIECE, 2'b00};
		pwdata <= {17'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.min_piece = value;
	endtask

	// stimulus
	initial begin
		logic [14:0] settings[6];
		logic [31:0] t, q;
		logic [23:0] d;
		int          phase_idx, next_phase, pick, mag, n;

		sent = 0;
		tx_steady = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing left right after reset
		send_emits(1);
		// moves longer in steps than in time are flagged
		send_request(sig_pkg::CMD_LOAD, 32'd5, 24'd10);
		send_request(sig_pkg::CMD_LOAD, 32'd0, 24'hFFFFFF);
		// extremes: full time, most negative and most positive distance
		send_request(sig_pkg::CMD_LOAD, 32'hFFFFFFFF, 24'h800000);
		send_emits(3);
		send_request(sig_pkg::CMD_LOAD, 32'hFFFFFFFF, 24'h7FFFFF);
		// interval just past the longest piece: halves, enable and disable
		send_request(sig_pkg::CMD_LOAD, 32'd130024, 24'd2);
		send_emits(10);
		// load in the middle of a piece, then a zero-distance move
		send_request(sig_pkg::CMD_LOAD, 32'd300000, 24'd1);
		send_emits(2);
		send_request(sig_pkg::CMD_LOAD, 32'd70000, 24'd0);
		send_emits(3);
		// empty move
		send_request(sig_pkg::CMD_LOAD, 32'd0, 24'd0);
		send_emits(1);

		settings[0] = 15'd16384;
		settings[1] = 15'd1;
		settings[2] = 15'd0;
		settings[3] = 15'h7FFF;
		settings[4] = 15'($urandom_range(1, 16384));
		settings[5] = sig_pkg::MIN_PIECE_RST;
		phase_idx = 0;
		next_phase = sent;

		while (sent < ITEM_TARGET) begin
			// new shortest piece between phases, block idle
			if (sent >= next_phase && phase_idx < 6) begin
				s_tvalid <= 1'b0;
				wait_drained();
				repeat (8) @(posedge clk);
				write_min_piece(settings[phase_idx]);
				if (phase_idx == 1)
					hold_req <= hold_req + 1;
				phase_idx++;
				next_phase = sent + PHASE_ITEMS;
			end
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				// well-formed move followed by its atoms
				mag = $urandom_range(1, 6);
				q = $urandom_range(0, 1) ? $urandom_range(1, 300) : $urandom_range(1, 150000);
				t = q * mag + $urandom_range(0, mag - 1);
				d = $urandom_range(0, 1) ? 24'(-mag) : 24'(mag);
				send_request(sig_pkg::CMD_LOAD, t, d);
				n = mag * (q / 40000 + 3) + 2;
				if (n > 40)
					n = 40;
				send_emits($urandom_range(n / 2, n));
			end else if (pick < 70) begin
				send_request(sig_pkg::CMD_LOAD, $urandom_range(0, 200000), 24'd0);
				send_emits($urandom_range(1, 6));
			end else if (pick < 80) begin
				send_request(sig_pkg::CMD_LOAD, $urandom, 24'($urandom));
				send_emits($urandom_range(0, 5));
			end else if (pick < 88) begin
				t = $urandom_range(0, 1000);
				mag = t + $urandom_range(1, 5000);
				d = $urandom_range(0, 1) ? 24'(-mag) : 24'(mag);
				send_request(sig_pkg::CMD_LOAD, t, d);
			end else begin
				send_request(1'($urandom_range(0, 1)), $urandom, 24'($urandom));
			end
			// now and then wait for every outstanding atom
			if ($urandom_range(0, 19) == 0) begin
				s_tvalid <= 1'b0;
				wait_drained();
			end
		end

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (50) @(posedge clk);
		if (tracker.atoms_due.size() != 0)
			tracker.note_failure("atoms still expected at the end");
		if (tracker.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/sig_pkg.sv
hw/rtl/stepper_interval_generator.sv
sim/stepper_interval_generator_test.sv
